/* rtl/gilbert_index_to_xy_top_defines.svh */
// Assertion macros for the index-to-coordinate block.
// Both macros sample on clk_i and are switched off while rst_ni is low.
`ifndef GILBERT_INDEX_TO_XY_TOP_DEFINES_SVH
`define GILBERT_INDEX_TO_XY_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GIXY_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GIXY_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/gixy_pkg.sv */
package gixy_pkg;

  localparam int unsigned IDX_BITS      = 32;
  localparam int unsigned DIM_BITS      = 16;
  localparam int unsigned MUL_BITS      = DIM_BITS;
  localparam int unsigned PROD_BITS     = 2 * MUL_BITS;
  localparam int unsigned CUR_BITS      = IDX_BITS + 1;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_ADDR_BITS = 3;

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(1);

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

/* rtl/gilbert_index_to_xy_top.sv */
// An index is taken in S_IDLE, S_AREA multiplies width by height and S_INIT checks the index.
// An out-of-range index goes on to S_WRITE; otherwise each subdivision round runs S_EVAL, S_MUL1
// and S_CMP1, and a three-way split may add S_MUL2 and S_CMP2, on the shared 16x16 multiplier.
// The input stalls for the whole walk and while the result waits to be written out.
// A finished result waits in the output register while the next item is accepted.
// Reset clears grid_width and grid_height to 1 and empties the block.
`include "gilbert_index_to_xy_top_defines.svh"

module gilbert_index_to_xy_top #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [gixy_pkg::CFG_ADDR_BITS-1:0]   paddr,
  input  logic [gixy_pkg::CFG_DATA_BITS-1:0]   pwdata,
  output logic [gixy_pkg::CFG_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [gixy_pkg::IDX_BITS-1:0]        curve_index_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [COORD_BITS-1:0]                x_coord_o,
  output logic [COORD_BITS-1:0]                y_coord_o,
  output logic                                 out_of_range_o
);

  import gixy_pkg::*;

  localparam int unsigned DW         = (COORD_BITS < DIM_BITS) ? COORD_BITS : DIM_BITS;
  localparam int unsigned VB         = COORD_BITS + 2;
  localparam int unsigned MAX_ROUNDS = 4 * COORD_BITS + 8;
  localparam int unsigned RW         = $clog2(MAX_ROUNDS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_AREA, S_INIT, S_EVAL, S_MUL1, S_CMP1, S_MUL2, S_CMP2, S_WRITE
  } state_e;

  typedef logic signed [VB-1:0] vec_t;

  function automatic logic [VB-1:0] mag_f(input vec_t v);
    return v[VB-1] ? -v : v;
  endfunction

  function automatic vec_t sgn_f(input vec_t v);
    if (v > 0) begin
      return {{(VB-1){1'b0}}, 1'b1};
    end else if (v < 0) begin
      return {VB{1'b1}};
    end else begin
      return '0;
    end
  endfunction

  function automatic vec_t step_f(input vec_t v, input vec_t d);
    if (v > 0) begin
      return d;
    end else if (v < 0) begin
      return -d;
    end else begin
      return '0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DIM_BITS-1:0] width_q, height_q;
  cfg_reg_e            cfg_sel;
  logic                cfg_wr;

  assign pready  = 1'b1;
  assign cfg_sel = cfg_reg_e'(paddr[CFG_ADDR_BITS-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRID_WIDTH:  width_q  <= pwdata[DIM_BITS-1:0];
        REG_GRID_HEIGHT: height_q <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRID_WIDTH:  prdata = CFG_DATA_BITS'(width_q);
      REG_GRID_HEIGHT: prdata = CFG_DATA_BITS'(height_q);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Walk state
  // ---------------------------------------------------------------------------
  state_e                state_q, state_d;
  logic [RW-1:0]         round_q, round_d;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] xo_q, xo_d, yo_q, yo_d;
  logic                  oor_out_q, oor_out_d;

  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [CUR_BITS-1:0]   cur_q, cur_d;
  vec_t                  ax_q, ax_d, ay_q, ay_d, bx_q, bx_d, by_q, by_d;
  vec_t                  x_q, x_d, y_q, y_d;
  vec_t                  a2x_q, a2x_d, a2y_q, a2y_d, b2x_q, b2x_d, b2y_q, b2y_d;
  logic [MUL_BITS-1:0]   wl_q, wl_d, hl_q, hl_d;
  logic [MUL_BITS-1:0]   ma2_q, ma2_d, mb2_q, mb2_d, mrest_q, mrest_d;
  logic                  long_q, long_d;
  logic                  oor_q, oor_d;
  logic [PROD_BITS-1:0]  prod_q, prod_d;

  // Shared multiplier and the compare that follows it
  logic [MUL_BITS-1:0]   mul_a, mul_b;
  logic [DW-1:0]         w_dim, h_dim;
  logic [CUR_BITS-1:0]   idx_ext, nxt;
  logic                  in_sub;

  // Round evaluation
  vec_t                  sum_a, sum_b, ax_h, ay_h, bx_h, by_h, dax, day, dbx, dby, di;
  vec_t                  a2x_n, a2y_n, b2x_n, b2y_n;
  logic [VB-1:0]         wl, hl;
  logic [VB+1:0]         wl_x2, hl_x3;
  logic                  long_n, bump_a, bump_b;
  logic                  load_out;

  assign w_dim   = width_q[DW-1:0];
  assign h_dim   = height_q[DW-1:0];
  assign idx_ext = {1'b0, idx_q};
  assign nxt     = cur_q + CUR_BITS'(prod_q);
  assign in_sub  = idx_ext < nxt;

  always_comb begin
    case (state_q)
      S_AREA: begin
        mul_a = MUL_BITS'(w_dim);
        mul_b = MUL_BITS'(h_dim);
      end
      S_MUL1: begin
        mul_a = long_q ? ma2_q : mb2_q;
        mul_b = long_q ? hl_q : ma2_q;
      end
      S_MUL2: begin
        mul_a = wl_q;
        mul_b = mrest_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_comb begin
    sum_a  = ax_q + ay_q;
    sum_b  = bx_q + by_q;
    wl     = mag_f(sum_a);
    hl     = mag_f(sum_b);
    dax    = sgn_f(ax_q);
    day    = sgn_f(ay_q);
    dbx    = sgn_f(bx_q);
    dby    = sgn_f(by_q);
    di     = VB'(idx_ext - cur_q);
    ax_h   = ax_q >>> 1;
    ay_h   = ay_q >>> 1;
    bx_h   = bx_q >>> 1;
    by_h   = by_q >>> 1;
    wl_x2  = {1'b0, wl, 1'b0};
    hl_x3  = {1'b0, hl, 1'b0} + {2'b00, hl};
    long_n = wl_x2 > hl_x3;
    // An odd half is bumped away from zero so that both parts stay even.
    bump_a = (ax_h[0] ^ ay_h[0]) && (wl > VB'(2));
    bump_b = (bx_h[0] ^ by_h[0]) && (hl > VB'(2));
    a2x_n  = (long_n && bump_a) ? ax_h + dax : ax_h;
    a2y_n  = (long_n && bump_a) ? ay_h + day : ay_h;
    b2x_n  = (!long_n && bump_b) ? bx_h + dbx : bx_h;
    b2y_n  = (!long_n && bump_b) ? by_h + dby : by_h;
  end

  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    out_valid_d = out_valid_q && out_stall_i;
    xo_d        = xo_q;
    yo_d        = yo_q;
    oor_out_d   = oor_out_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    bx_d        = bx_q;
    by_d        = by_q;
    x_d         = x_q;
    y_d         = y_q;
    a2x_d       = a2x_q;
    a2y_d       = a2y_q;
    b2x_d       = b2x_q;
    b2y_d       = b2y_q;
    wl_d        = wl_q;
    hl_d        = hl_q;
    ma2_d       = ma2_q;
    mb2_d       = mb2_q;
    mrest_d     = mrest_q;
    long_d      = long_q;
    oor_d       = oor_q;
    load_out    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d   = curve_index_i;
          cur_d   = '0;
          round_d = '0;
          state_d = S_AREA;
        end
      end
      S_AREA: begin
        state_d = S_INIT;
      end
      S_INIT: begin
        x_d = '0;
        y_d = '0;
        if (idx_q >= prod_q) begin
          oor_d   = 1'b1;
          state_d = S_WRITE;
        end else begin
          oor_d = 1'b0;
          // The curve runs along the longer side first.
          if (w_dim >= h_dim) begin
            ax_d = VB'(w_dim);
            ay_d = '0;
            bx_d = '0;
            by_d = VB'(h_dim);
          end else begin
            ax_d = '0;
            ay_d = VB'(h_dim);
            bx_d = VB'(w_dim);
            by_d = '0;
          end
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (round_q == RW'(MAX_ROUNDS)) begin
          state_d = S_WRITE;
        end else if (hl == VB'(1)) begin
          x_d     = x_q + step_f(ax_q, di);
          y_d     = y_q + step_f(ay_q, di);
          state_d = S_WRITE;
        end else if (wl == VB'(1)) begin
          x_d     = x_q + step_f(bx_q, di);
          y_d     = y_q + step_f(by_q, di);
          state_d = S_WRITE;
        end else begin
          a2x_d   = a2x_n;
          a2y_d   = a2y_n;
          b2x_d   = b2x_n;
          b2y_d   = b2y_n;
          wl_d    = MUL_BITS'(wl);
          hl_d    = MUL_BITS'(hl);
          ma2_d   = MUL_BITS'(mag_f(a2x_n + a2y_n));
          mb2_d   = MUL_BITS'(mag_f(b2x_n + b2y_n));
          mrest_d = MUL_BITS'(mag_f((bx_q - b2x_n) + (by_q - b2y_n)));
          long_d  = long_n;
          round_d = round_q + RW'(1);
          state_d = S_MUL1;
        end
      end
      S_MUL1: begin
        state_d = S_CMP1;
      end
      S_CMP1: begin
        if (long_q) begin
          if (in_sub) begin
            ax_d = a2x_q;
            ay_d = a2y_q;
          end else begin
            cur_d = nxt;
            x_d   = x_q + a2x_q;
            y_d   = y_q + a2y_q;
            ax_d  = ax_q - a2x_q;
            ay_d  = ay_q - a2y_q;
          end
          state_d = S_EVAL;
        end else if (in_sub) begin
          ax_d    = b2x_q;
          ay_d    = b2y_q;
          bx_d    = a2x_q;
          by_d    = a2y_q;
          state_d = S_EVAL;
        end else begin
          cur_d   = nxt;
          state_d = S_MUL2;
        end
      end
      S_MUL2: begin
        state_d = S_CMP2;
      end
      S_CMP2: begin
        if (in_sub) begin
          x_d  = x_q + b2x_q;
          y_d  = y_q + b2y_q;
          bx_d = bx_q - b2x_q;
          by_d = by_q - b2y_q;
        end else begin
          // Last third: step back down and turn the frame round.
          cur_d = nxt;
          x_d   = x_q + (ax_q - dax) + (b2x_q - dbx);
          y_d   = y_q + (ay_q - day) + (b2y_q - dby);
          ax_d  = -b2x_q;
          ay_d  = -b2y_q;
          bx_d  = a2x_q - ax_q;
          by_d  = a2y_q - ay_q;
        end
        state_d = S_EVAL;
      end
      S_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          xo_d        = oor_q ? '0 : x_q[COORD_BITS-1:0];
          yo_d        = oor_q ? '0 : y_q[COORD_BITS-1:0];
          oor_out_d   = oor_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
      xo_q        <= '0;
      yo_q        <= '0;
      oor_out_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
      xo_q        <= xo_d;
      yo_q        <= yo_d;
      oor_out_q   <= oor_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    x_q     <= x_d;
    y_q     <= y_d;
    a2x_q   <= a2x_d;
    a2y_q   <= a2y_d;
    b2x_q   <= b2x_d;
    b2y_q   <= b2y_d;
    wl_q    <= wl_d;
    hl_q    <= hl_d;
    ma2_q   <= ma2_d;
    mb2_q   <= mb2_d;
    mrest_q <= mrest_d;
    long_q  <= long_d;
    oor_q   <= oor_d;
    prod_q  <= prod_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign x_coord_o      = xo_q;
  assign y_coord_o      = yo_q;
  assign out_of_range_o = oor_out_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `GIXY_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "item accepted while idle but block not busy next cycle")
  `GIXY_ASSERT_NOW(a_oor_zero_coords, out_valid_o && out_of_range_o, x_coord_o == '0 && y_coord_o == '0, "out-of-range result carries non-zero coordinates")
  `GIXY_ASSERT_NOW(a_cur_not_past_idx, state_q != S_IDLE, cur_q <= idx_ext, "walk start position has passed the index")
  `GIXY_ASSERT_NEXT(a_result_held, state_q == S_WRITE && out_valid_q && out_stall_i && !load_out, state_q == S_WRITE, "finished result dropped while output register full")

endmodule
